>>> hw/rtl/bsbh_pkg.sv
// Package for the byte string bucket hash block.
// Holds the shared types and constants; no dependencies.
`default_nettype none

package bsbh_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned DIV_STEPS       = 32;
    localparam int unsigned DIV_CNT_W       = $clog2(DIV_STEPS);
    localparam logic [31:0] BUCKET_RESET    = 32'd256;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ADD,
        OP_MUL
    } bsbh_op_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FIN,
        ST_DIV,
        ST_DONE
    } bsbh_state_t;

    typedef struct packed {
        bsbh_op_t    op;
        logic [31:0] term;
        logic [15:0] len;
        logic        last;
    } bsbh_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/bsbh_front.sv
// Front end: accepts key bytes, tracks the byte position and forms each byte's term.
// Depends on bsbh_pkg.
`default_nettype none

module bsbh_front
    import bsbh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [7:0]  key_byte,
    input  wire logic [15:0] key_length,
    input  wire logic        q_full,
    output logic             q_push,
    output bsbh_item_t       q_item
);

    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [16:0] pos_plus;
    logic        last;
    logic [23:0] prod_len;
    logic [23:0] prod_pos;
    logic [24:0] mul_term;

    assign q_push   = push && !q_full;
    assign pos_plus = {1'b0, pos_reg} + 17'd1;
    assign last     = !(pos_plus < {1'b0, key_length});
    assign prod_len = {16'd0, key_byte} * {8'd0, key_length};
    assign prod_pos = {16'd0, key_byte} * {8'd0, pos_reg};
    assign mul_term = {1'b0, prod_pos} + {9'd0, key_length} + {9'd0, pos_reg};

    always_comb
    begin
        q_item.len  = key_length;
        q_item.last = last;
        if (pos_reg == 16'd0)
        begin
            q_item.op   = OP_LOAD;
            q_item.term = {24'd0, key_byte};
        end
        else if (pos_reg == 16'd1)
        begin
            q_item.op   = OP_ADD;
            q_item.term = {8'd0, prod_len};
        end
        else
        begin
            q_item.op   = OP_MUL;
            q_item.term = {7'd0, mul_term};
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            pos_next = last ? 16'd0 : pos_plus[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bsbh_queue.sv
// Short queue of classified words between the front end and the back end.
// Depends on bsbh_pkg.
`default_nettype none

module bsbh_queue
    import bsbh_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire bsbh_item_t  wr_item,
    output logic             full,
    input  wire logic        rd_en,
    output logic             rd_valid,
    output bsbh_item_t       rd_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    bsbh_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (cnt_reg == CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bsbh_back.sv
// Back end: accumulator update, final multiply, bit-serial modulo and result register.
// Depends on bsbh_pkg.
`default_nettype none

module bsbh_back
    import bsbh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] bucket_count,
    input  wire logic        q_valid,
    input  wire bsbh_item_t  q_item,
    output logic             q_pop,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      bucket_index
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    bsbh_state_t          state_reg;
    bsbh_state_t          state_next;
    logic [31:0]          acc_reg;
    logic [31:0]          acc_next;
    logic [15:0]          len_reg;
    logic [15:0]          len_next;
    logic [31:0]          dvd_reg;
    logic [31:0]          dvd_next;
    logic [31:0]          rem_reg;
    logic [31:0]          rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [31:0]          out_reg;
    logic [31:0]          out_next;
    logic [31:0]          acc_calc;
    logic [31:0]          fin_prod;
    logic [32:0]          shifted;
    logic [32:0]          divisor;
    logic                 out_free;
    logic                 out_load;

    assign empty        = !out_valid_reg;
    assign bucket_index = out_reg;
    assign out_free     = !out_valid_reg || pop;
    assign fin_prod     = 32'(acc_reg * {16'd0, len_reg});
    assign shifted      = {rem_reg, dvd_reg[31]};
    assign divisor      = {1'b0, bucket_count};

    always_comb
    begin
        case (q_item.op)
            OP_LOAD: acc_calc = q_item.term;
            OP_ADD:  acc_calc = acc_reg + q_item.term;
            OP_MUL:  acc_calc = 32'(acc_reg * q_item.term);
            default: acc_calc = acc_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (q_valid && q_item.last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = (bucket_count == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        acc_next = acc_reg;
        len_next = len_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_RUN:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    acc_next = acc_calc;
                    len_next = q_item.len;
                end
            end
            ST_FIN:
            begin
                cnt_next = '0;
                dvd_next = fin_prod;
                rem_next = (bucket_count == '0) ? fin_prod : '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                dvd_next = {dvd_reg[30:0], 1'b0};
                rem_next = (shifted >= divisor) ? 32'(shifted - divisor) : shifted[31:0];
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        if (out_load)
        begin
            out_next       = rem_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        len_reg <= len_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The final multiply leads either into the division or straight to the result.
    a_fin_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> (state_reg == ST_DIV || state_reg == ST_DONE))
        else $error("final multiply did not move on");

    // The division moves on to the result after its last step.
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_LAST) |=> state_reg == ST_DONE)
        else $error("division did not finish after its last step");

    // The partial remainder always stays below the bucket count.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < bucket_count)
        else $error("partial remainder out of range");

    // A finished result waits without change while the output word is still held.
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !pop)
        |=> (state_reg == ST_DONE && $stable(rem_reg)))
        else $error("result lost while output was stalled");

endmodule

`default_nettype wire

>>> hw/rtl/byte_string_bucket_hash.sv
// Top level of the byte string bucket hash block.
// Depends on bsbh_pkg, bsbh_front, bsbh_queue and bsbh_back.
//
// A key enters one byte per word, each word carrying the key's total length; the word
// that completes the key yields one bucket index. The front end takes a byte every cycle
// into a short queue while it is not full, and the back end retires one byte per cycle,
// when not finishing a key, through a single 32-bit multiplier in its accumulator loop.
// The last byte of a key takes an accumulator update, a final multiply by the length,
// 32 bit-serial remainder steps and a load of the result register. bucket_count may
// be written only while the block is idle; zero gives the unreduced product.
`default_nettype none

module byte_string_bucket_hash
    import bsbh_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  key_byte,
    input  wire logic [15:0] key_length,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      bucket_index
);

    logic [31:0] bucket_count_reg;
    logic [31:0] bucket_count_next;
    logic        q_full;
    logic        q_push;
    logic        q_valid;
    logic        q_pop;
    bsbh_item_t  wr_item;
    bsbh_item_t  rd_item;

    assign full              = q_full;
    assign bucket_count_next = cfg_we ? cfg_wdata : bucket_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_RESET;
        end
        else
        begin
            bucket_count_reg <= bucket_count_next;
        end
    end

    bsbh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .key_byte   (key_byte),
        .key_length (key_length),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (wr_item)
    );

    bsbh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_item  (wr_item),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (rd_item)
    );

    bsbh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .bucket_count (bucket_count_reg),
        .q_valid      (q_valid),
        .q_item       (rd_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .bucket_index (bucket_index)
    );

endmodule

`default_nettype wire

>>> verif/byte_string_bucket_hash_test.sv
// Self-checking test for byte_string_bucket_hash: streams key bytes through the queue ports
// and compares every bucket index against a cycle-free hash predictor.
// Depends on bsbh_pkg and the byte_string_bucket_hash RTL.
module byte_string_bucket_hash_test
    import bsbh_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned PHASE_WORDS   = 230;
    localparam int unsigned PRINT_LIMIT   = 50;

    typedef struct packed {
        logic [7:0]  kbyte;
        logic [15:0] klen;
    } key_word_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [31:0] cfg_wdata  = '0;
    logic        push       = 1'b0;
    logic [7:0]  key_byte   = '0;
    logic [15:0] key_length = '0;
    logic        pop        = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] bucket_index;

    key_word_t   pending_words[$];
    logic [31:0] expected_index[$];
    key_word_t   next_word;
    logic [31:0] want_index;
    logic [31:0] buckets  = BUCKET_RESET;
    logic [31:0] hash_acc = '0;
    logic [15:0] hash_pos = '0;
    int unsigned send_idle_pct = 0;
    int unsigned take_idle_pct = 0;
    int unsigned words_queued  = 0;
    int unsigned errors        = 0;
    int unsigned cycles        = 0;

    byte_string_bucket_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .key_byte     (key_byte),
        .key_length   (key_length),
        .empty        (empty),
        .pop          (pop),
        .bucket_index (bucket_index)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task note_error(input string what);
        if (errors < PRINT_LIMIT)
        begin
            $display("ERROR at cycle %0d: %s", cycles, what);
        end
        errors++;
    endtask

    function void advance_hash(input logic [7:0] kbyte, input logic [15:0] klen);
        logic [31:0] b;
        logic [31:0] len;
        logic [31:0] pos;
        logic [31:0] acc;
        logic [31:0] fin;
        b   = {24'd0, kbyte};
        len = {16'd0, klen};
        pos = {16'd0, hash_pos};
        acc = hash_acc;
        if (pos == 32'd0)
        begin
            acc = acc + b;
        end
        else if (pos == 32'd1)
        begin
            acc = acc + b * len;
        end
        else
        begin
            acc = acc * (b * pos + len + pos);
        end
        if (pos + 32'd1 < len)
        begin
            hash_acc = acc;
            hash_pos = hash_pos + 16'd1;
        end
        else
        begin
            fin = acc * len;
            if (buckets != 32'd0)
            begin
                fin = fin % buckets;
            end
            expected_index.push_back(fin);
            hash_acc = '0;
            hash_pos = '0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                advance_hash(key_byte, key_length);
            end
            if (!push || !full)
            begin
                if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    push       <= 1'b1;
                    key_byte   <= next_word.kbyte;
                    key_length <= next_word.klen;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_index.size() == 0)
                begin
                    note_error($sformatf("unexpected word, bucket_index %h", bucket_index));
                end
                else
                begin
                    want_index = expected_index.pop_front();
                    if (bucket_index !== want_index)
                    begin
                        note_error($sformatf("bucket_index %h, expected %h",
                                             bucket_index, want_index));
                    end
                end
            end
            pop <= ($urandom_range(99, 0) >= take_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task add_word(input logic [7:0] kbyte, input logic [15:0] klen);
        pending_words.push_back(key_word_t'{kbyte: kbyte, klen: klen});
        words_queued++;
    endtask

    task queue_random_key;
        int unsigned nominal;
        int unsigned pos;
        int unsigned len;
        int unsigned pick;
        logic [7:0]  b;
        bit          done;
        pick = $urandom_range(99, 0);
        if (pick < 70)
        begin
            nominal = $urandom_range(8, 1);
        end
        else if (pick < 90)
        begin
            nominal = $urandom_range(40, 9);
        end
        else
        begin
            nominal = $urandom_range(65535, 41);
        end
        pos  = 0;
        done = 1'b0;
        while (!done)
        begin
            len = nominal;
            // An occasional word changes the length in the middle of a key.
            if ($urandom_range(99, 0) < 4)
            begin
                len = $urandom_range(65535, 1);
            end
            // Long keys are cut short by a length that the position has already reached.
            if ((nominal > 40 && pos >= 3 && $urandom_range(3, 0) == 0) || pos >= 48)
            begin
                len = $urandom_range(pos + 1, 1);
            end
            pick = $urandom_range(9, 0);
            b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom());
            add_word(b, 16'(len));
            if (pos + 1 >= len)
            begin
                done = 1'b1;
            end
            else
            begin
                pos++;
            end
        end
    endtask

    task queue_phase(input int unsigned count);
        int unsigned start;
        start = words_queued;
        while (words_queued - start < count)
        begin
            queue_random_key();
        end
    endtask

    task wait_drained;
        while (pending_words.size() != 0 || push || expected_index.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task write_buckets(input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        buckets = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] setting;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short keys at the byte extremes, then keys whose length changes part way.
        add_word(8'h00, 16'd1);
        add_word(8'hFF, 16'd1);
        add_word(8'hFF, 16'd2);
        add_word(8'hFF, 16'd2);
        add_word(8'hAB, 16'd3);
        add_word(8'h00, 16'd3);
        add_word(8'hFF, 16'd3);
        add_word(8'h12, 16'hFFFF);
        add_word(8'h34, 16'hFFFF);
        add_word(8'h56, 16'd2);
        add_word(8'h01, 16'd2);
        add_word(8'h02, 16'd5);
        add_word(8'h03, 16'd5);
        add_word(8'h04, 16'd5);
        add_word(8'h05, 16'd5);
        add_word(8'h80, 16'h8000);
        add_word(8'h7F, 16'h7FFF);
        add_word(8'h55, 16'd1);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase < 2)
            begin
                send_idle_pct = 9;
                take_idle_pct = 83;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 83;
                take_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            case (phase)
                0:       setting = 32'd0;
                1:       setting = 32'hFFFF_FFFF;
                2:       setting = 32'd1;
                3:       setting = $urandom();
                4:       setting = 32'd1000003;
                default: setting = 32'd256;
            endcase
            write_buckets(setting);
            queue_phase(PHASE_WORDS / 2);
            if (phase == 1)
            begin
                wait_drained();
            end
            queue_phase(PHASE_WORDS / 2);
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
        end

        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
